// ===== sv/rogn_pkg.sv =====
`default_nettype none

package rogn_pkg;

  localparam int CHANNEL_BITS = 16;
  localparam int FRAC_BITS    = 12;
  localparam int NUM_CH       = 3;

  // Quotient is at most 1.0, so one integer bit on top of the fraction
  localparam int OUT_W     = FRAC_BITS + 1;
  // Partial remainder stays below the divisor; one extra bit after the shift
  localparam int REM_W     = CHANNEL_BITS + 1;
  // Width wide enough to hold both a channel and the value 1.0
  localparam int CMP_W     = (CHANNEL_BITS > OUT_W) ? CHANNEL_BITS : OUT_W;
  // One quotient bit per divider stage
  localparam int DIV_STEPS = OUT_W;
  // Peak stage, divider stages, output register
  localparam int LATENCY   = DIV_STEPS + 2;

  localparam logic [CMP_W-1:0] ONE_CMP = CMP_W'(1) << FRAC_BITS;
  localparam logic [OUT_W-1:0] ONE_FRAC = OUT_W'(1) << FRAC_BITS;

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic [OUT_W-1:0]        frac_t;
  typedef logic [REM_W-1:0]        rem_t;

  typedef struct packed {
    chan_t red_in;
    chan_t green_in;
    chan_t blue_in;
  } rgb_in_t;

  typedef struct packed {
    frac_t red_out;
    frac_t green_out;
    frac_t blue_out;
    logic  was_scaled;
  } rgb_out_t;

  typedef struct packed {
    logic                   valid;
    logic                   scaled;
    chan_t                  divisor;
    chan_t [NUM_CH-1:0]     chans;
  } peak_stage_t;

  typedef struct packed {
    logic  scaled;
    chan_t divisor;
  } ctrl_t;

  // Low bits of a channel, zero-extended where the channel is narrower
  function automatic frac_t to_frac(chan_t c);
    logic [CMP_W-1:0] ext;
    ext = CMP_W'(c);
    return ext[OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/rogn_peak.sv =====
`default_nettype none

module rogn_peak (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire rogn_pkg::rgb_in_t     in_px,
  output rogn_pkg::peak_stage_t      peak_o
);
  import rogn_pkg::*;

  logic               valid_r;
  logic               scaled_r;
  chan_t              divisor_r;
  chan_t [NUM_CH-1:0] chans_r;

  chan_t peak_rg;
  chan_t peak_nxt;
  logic  scaled_nxt;

  always_comb begin
    peak_rg    = (in_px.green_in > in_px.red_in) ? in_px.green_in : in_px.red_in;
    peak_nxt   = (in_px.blue_in > peak_rg) ? in_px.blue_in : peak_rg;
    // Exactly 1.0 passes through untouched
    scaled_nxt = CMP_W'(peak_nxt) > ONE_CMP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    scaled_r   <= scaled_nxt;
    divisor_r  <= peak_nxt;
    chans_r[0] <= in_px.red_in;
    chans_r[1] <= in_px.green_in;
    chans_r[2] <= in_px.blue_in;
  end

  assign peak_o = '{valid: valid_r, scaled: scaled_r, divisor: divisor_r, chans: chans_r};

endmodule

`default_nettype wire

// ===== sv/rogn_div_lane.sv =====
`default_nettype none

module rogn_div_lane (
  input  wire logic                                   clk,
  input  wire rogn_pkg::chan_t                        chan_i,
  input  wire rogn_pkg::chan_t [rogn_pkg::DIV_STEPS-1:0] divisor_i,
  output rogn_pkg::frac_t                             quot_o,
  output rogn_pkg::frac_t                             pass_o
);
  import rogn_pkg::*;

  rem_t  rem_r  [DIV_STEPS-1];
  frac_t quot_r [DIV_STEPS];
  frac_t pass_r [DIV_STEPS];

  // Restoring division, one quotient bit per stage, most significant first.
  // The channel never exceeds the divisor, so the first step needs no shift.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    rem_t  trial;
    rem_t  rem_nxt;
    logic  ge;
    frac_t quot_nxt;
    frac_t pass_nxt;

    if (k == 0) begin : g_first
      assign trial    = REM_W'(chan_i);
      assign quot_nxt = OUT_W'(ge);
      assign pass_nxt = to_frac(chan_i);
    end else begin : g_next
      assign trial    = {rem_r[k-1][REM_W-2:0], 1'b0};
      assign quot_nxt = {quot_r[k-1][OUT_W-2:0], ge};
      assign pass_nxt = pass_r[k-1];
    end

    assign ge      = trial >= REM_W'(divisor_i[k]);
    assign rem_nxt = ge ? (trial - REM_W'(divisor_i[k])) : trial;

    always_ff @(posedge clk) begin
      quot_r[k] <= quot_nxt;
      pass_r[k] <= pass_nxt;
    end

    if (k < DIV_STEPS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem_r[k] <= rem_nxt;
      end
    end
  end

  assign quot_o = quot_r[DIV_STEPS-1];
  assign pass_o = pass_r[DIV_STEPS-1];

endmodule

`default_nettype wire

// ===== sv/rogn_merge.sv =====
`default_nettype none

module rogn_merge (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 valid_i,
  input  wire logic                                 scaled_i,
  input  wire rogn_pkg::frac_t [rogn_pkg::NUM_CH-1:0] quot_i,
  input  wire rogn_pkg::frac_t [rogn_pkg::NUM_CH-1:0] pass_i,
  output logic                                      out_valid,
  output rogn_pkg::rgb_out_t                        out_data
);
  import rogn_pkg::*;

  logic     valid_r;
  rgb_out_t data_r;
  rgb_out_t data_nxt;

  // Pick the quotient for scaled pixels, the original channel otherwise
  always_comb begin
    data_nxt.red_out    = scaled_i ? quot_i[0] : pass_i[0];
    data_nxt.green_out  = scaled_i ? quot_i[1] : pass_i[1];
    data_nxt.blue_out   = scaled_i ? quot_i[2] : pass_i[2];
    data_nxt.was_scaled = scaled_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

// ===== sv/rgb_out_of_gamut_normalizer.sv =====
// RGB out-of-gamut normaliser. Takes one pixel per clock (start high while
// busy is low) and returns it as a single-cycle out_valid strobe after the
// peak stage, which finds the peak channel, the 13-stage pipelined divider
// that each of the three channel lanes owns, one quotient bit per stage, and
// one output register. Pixels may follow each other on every clock and
// the result cannot be stalled, so the receiver must take it when it shows.
// busy is high only while reset is held.
`default_nettype none

module rgb_out_of_gamut_normalizer (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire rogn_pkg::rgb_in_t   in_data,
  output logic                     out_valid,
  output rogn_pkg::rgb_out_t       out_data
);
  import rogn_pkg::*;

  peak_stage_t               peak;
  logic                      valid_r [DIV_STEPS];
  ctrl_t                     ctrl_r  [DIV_STEPS];
  chan_t [DIV_STEPS-1:0]     div_vec;
  frac_t [NUM_CH-1:0]        quot;
  frac_t [NUM_CH-1:0]        pass;

  // Hold off transactions while in reset
  assign busy = ~rst_n;

  rogn_peak u_peak (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start & ~busy),
    .in_px    (in_data),
    .peak_o   (peak)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        valid_r[k] <= 1'b0;
      end
    end else begin
      valid_r[0] <= peak.valid;
      for (int k = 1; k < DIV_STEPS; k++) begin
        valid_r[k] <= valid_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    ctrl_r[0] <= '{scaled: peak.scaled, divisor: peak.divisor};
    for (int k = 1; k < DIV_STEPS; k++) begin
      ctrl_r[k] <= ctrl_r[k-1];
    end
  end

  // Divisor that travels alongside each divider stage's input
  always_comb begin
    div_vec[0] = peak.divisor;
    for (int k = 1; k < DIV_STEPS; k++) begin
      div_vec[k] = ctrl_r[k-1].divisor;
    end
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    rogn_div_lane u_lane (
      .clk       (clk),
      .chan_i    (peak.chans[c]),
      .divisor_i (div_vec),
      .quot_o    (quot[c]),
      .pass_o    (pass[c])
    );
  end

  rogn_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (valid_r[DIV_STEPS-1]),
    .scaled_i  (ctrl_r[DIV_STEPS-1].scaled),
    .quot_i    (quot),
    .pass_i    (pass),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== sv/rogn_checker.sv =====
`default_nettype none

module rogn_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire rogn_pkg::rgb_in_t   in_data,
  input wire logic                out_valid,
  input wire rogn_pkg::rgb_out_t  out_data
);
  import rogn_pkg::*;

  // Every accepted transaction comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted pixel did not emerge after the pipeline latency");

  // No result without a transaction that matches it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a matching accepted pixel");

  // Scaling decision follows the peak of the matching input
  a_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.was_scaled ==
      ($past(in_data.red_in > CHANNEL_BITS'(ONE_CMP), LATENCY) ||
       $past(in_data.green_in > CHANNEL_BITS'(ONE_CMP), LATENCY) ||
       $past(in_data.blue_in > CHANNEL_BITS'(ONE_CMP), LATENCY))))
    else $error("was_scaled disagrees with the input peak");

  // A scaled pixel has its peak channel at exactly 1.0
  a_peak_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.was_scaled) |->
      (out_data.red_out == ONE_FRAC || out_data.green_out == ONE_FRAC ||
       out_data.blue_out == ONE_FRAC))
    else $error("scaled pixel has no channel at 1.0");

  // Nothing ever leaves above 1.0
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.red_out <= ONE_FRAC && out_data.green_out <= ONE_FRAC &&
                   out_data.blue_out <= ONE_FRAC))
    else $error("output channel above 1.0");

endmodule

bind rgb_out_of_gamut_normalizer rogn_checker u_rogn_checker (.*);

`default_nettype wire
